### rtl/fpba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpba_pkg
// shared types and codes of the fit-policy block allocator
// ----------------------------------------------------------------------------
package fpba_pkg;

  localparam int SIZE_W = 21;
  localparam int OFFS_W = 24;

  typedef enum logic [1:0] {
    POL_FIRST = 2'd0,
    POL_BEST  = 2'd1,
    POL_WORST = 2'd2,
    POL_NEXT  = 2'd3
  } policy_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_ZERO    = 2'd1,
    STAT_NO_ROOM = 2'd2,
    STAT_BAD_REL = 2'd3
  } status_t;

  typedef enum logic {
    MODE_ALLOC   = 1'b0,
    MODE_RELEASE = 1'b1
  } mode_t;

  typedef enum logic {
    REG_FIT_POLICY = 1'b0,
    REG_HEAP_LIMIT = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESOLVE,
    ST_REL_CHK
  } state_t;

  // one table entry
  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic              free;
    logic [OFFS_W-1:0] base;
  } entry_t;

  // verdict of the shared fit compare unit
  typedef struct packed {
    logic              fits;
    logic              better;
    logic [SIZE_W-1:0] excess;
  } verdict_t;

endpackage

### rtl/fpba_fit_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpba_fit_unit
// shared subtract and compare unit: does an entry fit, and does it beat the
// current best candidate under the best or worst fit rule
// ----------------------------------------------------------------------------
module fpba_fit_unit
  import fpba_pkg::*;
(
  input  entry_t            ent,
  input  logic [SIZE_W-1:0] need,
  input  policy_t           pol,
  input  logic              best_v,
  input  logic [SIZE_W-1:0] best_exc,
  output verdict_t          verdict
);

  logic [SIZE_W:0] diff;
  logic            cmp;

  assign diff = {1'b0, ent.size} - {1'b0, need};

  always_comb begin
    case (pol)
      POL_BEST:  cmp = diff[SIZE_W-1:0] < best_exc;
      POL_WORST: cmp = diff[SIZE_W-1:0] > best_exc;
      default:   cmp = 1'b0;
    endcase
    verdict.fits   = ent.free && !diff[SIZE_W];
    verdict.better = verdict.fits && (!best_v || cmp);
    verdict.excess = diff[SIZE_W-1:0];
  end

endmodule

### rtl/fit_policy_block_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fit_policy_block_allocator
// block-table heap allocator with first, best, worst and next fit search
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; exactly one result
// beat follows, shown for one cycle with out_valid, and it cannot be held
// off. A zero-size allocate answers in the next cycle, a release after the
// release check step. An allocate walks the block table one entry per cycle
// through the single read port of the table memory; first and next fit stop
// at the first hit, best and worst fit walk every entry. Next fit with a
// valid rover may walk the table twice. The table needs no clearing pass
// after reset: only entries below the block count are ever used.
// Registers: fit_policy at byte 0, heap_limit at byte 4; the user must
// write them only while the block is idle, which the block does not enforce.
// ----------------------------------------------------------------------------
module fit_policy_block_allocator
  import fpba_pkg::*;
#(
  parameter int MAX_BLOCKS   = 64,
  parameter int HEADER_BYTES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // command channel
  input  logic        start,
  output logic        busy,
  input  logic        in_mode,
  input  logic [19:0] in_request_size,
  input  logic [5:0]  in_release_index,
  // result channel
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic        out_grown,
  output logic [5:0]  out_block_index,
  output logic [23:0] out_data_offset,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int CMP_W = (CNT_W > 6) ? CNT_W : 6;
  localparam int END_W = OFFS_W + 2;

  // configuration registers
  policy_t           fit_policy_r;
  logic [OFFS_W-1:0] heap_limit_r;

  // sequencer and allocator state
  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [OFFS_W-1:0] heap_top_r, heap_top_nxt;
  logic [IDX_W-1:0]  rover_r, rover_nxt;
  logic              rover_v_r, rover_v_nxt;

  // per-command working registers
  policy_t           pol_r, pol_nxt;
  logic [SIZE_W-1:0] need_r, need_nxt;
  logic [5:0]        rel_r, rel_nxt;
  logic [CNT_W-1:0]  scan_i_r, scan_i_nxt;
  logic              phase1_r, phase1_nxt;
  logic              pend_v_r, pend_v_nxt;
  logic [IDX_W-1:0]  pend_idx_r, pend_idx_nxt;
  logic              found_r, found_nxt;
  logic [IDX_W-1:0]  pick_idx_r, pick_idx_nxt;
  entry_t            pick_ent_r, pick_ent_nxt;
  logic [SIZE_W-1:0] best_exc_r, best_exc_nxt;

  // result beat
  logic              out_valid_r, out_valid_nxt;
  status_t           status_r, status_nxt;
  logic              grown_r, grown_nxt;
  logic [5:0]        idx_r, idx_nxt;
  logic [OFFS_W-1:0] offs_r, offs_nxt;

  // table memory
  entry_t            blk_mem_r [MAX_BLOCKS];
  entry_t            mem_q_r;
  logic [IDX_W-1:0]  rd_addr;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_wa;
  entry_t            mem_wd;

  verdict_t          verdict;
  logic              accept;
  logic              issue;
  logic [END_W-1:0]  grow_end;
  logic              cfg_wr;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  // ---------------- register port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    case (reg_idx_t'(paddr[2]))
      REG_FIT_POLICY: prdata = {30'd0, fit_policy_r};
      REG_HEAP_LIMIT: prdata = {8'd0, heap_limit_r};
      default:        prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_policy_r <= POL_FIRST;
      heap_limit_r <= {OFFS_W{1'b1}};
    end else if (cfg_wr) begin
      case (reg_idx_t'(paddr[2]))
        REG_FIT_POLICY: fit_policy_r <= policy_t'(pwdata[1:0]);
        REG_HEAP_LIMIT: heap_limit_r <= pwdata[OFFS_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- table memory ----------------
  always_ff @(posedge clk) begin
    if (mem_we) begin
      blk_mem_r[mem_wa] <= mem_wd;
    end
    mem_q_r <= blk_mem_r[rd_addr];
  end

  // read address: release index while idle, scan pointer otherwise
  assign rd_addr = (state_r == ST_IDLE) ? IDX_W'(in_release_index)
                                        : scan_i_r[IDX_W-1:0];

  // shared compare unit works on the entry that just came out of memory
  fpba_fit_unit u_fit (
    .ent      (mem_q_r),
    .need     (need_r),
    .pol      (pol_r),
    .best_v   (found_r),
    .best_exc (best_exc_r),
    .verdict  (verdict)
  );

  assign issue    = scan_i_r < count_r;
  assign grow_end = END_W'(heap_top_r) + END_W'(HEADER_BYTES) + END_W'(need_r);

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    heap_top_nxt  = heap_top_r;
    rover_nxt     = rover_r;
    rover_v_nxt   = rover_v_r;
    pol_nxt       = pol_r;
    need_nxt      = need_r;
    rel_nxt       = rel_r;
    scan_i_nxt    = scan_i_r;
    phase1_nxt    = phase1_r;
    pend_v_nxt    = 1'b0;
    pend_idx_nxt  = pend_idx_r;
    found_nxt     = found_r;
    pick_idx_nxt  = pick_idx_r;
    pick_ent_nxt  = pick_ent_r;
    best_exc_nxt  = best_exc_r;
    out_valid_nxt = 1'b0;
    status_nxt    = status_r;
    grown_nxt     = grown_r;
    idx_nxt       = idx_r;
    offs_nxt      = offs_r;
    mem_we        = 1'b0;
    mem_wa        = pick_idx_r;
    mem_wd        = pick_ent_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          pol_nxt   = fit_policy_r;
          rel_nxt   = in_release_index;
          need_nxt  = (SIZE_W'(in_request_size) + SIZE_W'(3)) & ~SIZE_W'(3);
          found_nxt = 1'b0;
          if (mode_t'(in_mode) == MODE_RELEASE) begin
            // read was issued this cycle at the release index
            state_nxt = ST_REL_CHK;
          end else if (in_request_size == 20'd0) begin
            out_valid_nxt = 1'b1;
            status_nxt    = STAT_ZERO;
            grown_nxt     = 1'b0;
            idx_nxt       = 6'd0;
            offs_nxt      = '0;
          end else begin
            state_nxt = ST_SCAN;
            // next fit starts at a rover that is still inside the table
            if (fit_policy_r == POL_NEXT && rover_v_r &&
                CNT_W'(rover_r) < count_r) begin
              phase1_nxt = 1'b1;
              scan_i_nxt = CNT_W'(rover_r);
            end else begin
              phase1_nxt = 1'b0;
              scan_i_nxt = '0;
            end
          end
        end
      end

      ST_SCAN: begin
        // one read issued per cycle, checked in the next cycle
        pend_v_nxt   = issue;
        pend_idx_nxt = scan_i_r[IDX_W-1:0];
        if (issue) begin
          scan_i_nxt = scan_i_r + CNT_W'(1);
        end
        if (pend_v_r && verdict.fits &&
            (pol_r == POL_FIRST || pol_r == POL_NEXT)) begin
          found_nxt    = 1'b1;
          pick_idx_nxt = pend_idx_r;
          pick_ent_nxt = mem_q_r;
          pend_v_nxt   = 1'b0;
          state_nxt    = ST_RESOLVE;
        end else begin
          if (pend_v_r && verdict.better &&
              (pol_r == POL_BEST || pol_r == POL_WORST)) begin
            found_nxt    = 1'b1;
            pick_idx_nxt = pend_idx_r;
            pick_ent_nxt = mem_q_r;
            best_exc_nxt = verdict.excess;
          end
          if (!issue && !pend_v_r) begin
            if (phase1_r) begin
              // wrap around for the second pass from the head
              phase1_nxt = 1'b0;
              scan_i_nxt = '0;
            end else begin
              state_nxt = ST_RESOLVE;
            end
          end
        end
      end

      ST_RESOLVE: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
        if (found_r) begin
          mem_we        = 1'b1;
          mem_wa        = pick_idx_r;
          mem_wd        = pick_ent_r;
          mem_wd.free   = 1'b0;
          status_nxt    = STAT_OK;
          grown_nxt     = 1'b0;
          idx_nxt       = 6'(pick_idx_r);
          offs_nxt      = pick_ent_r.base + OFFS_W'(HEADER_BYTES);
          if (pol_r == POL_NEXT) begin
            rover_nxt   = pick_idx_r;
            rover_v_nxt = 1'b1;
          end
        end else begin
          if (pol_r == POL_NEXT) begin
            rover_nxt   = '0;
            rover_v_nxt = 1'b0;
          end
          if (count_r >= CNT_W'(MAX_BLOCKS) ||
              grow_end > END_W'(heap_limit_r)) begin
            status_nxt = STAT_NO_ROOM;
            grown_nxt  = 1'b0;
            idx_nxt    = 6'd0;
            offs_nxt   = '0;
          end else begin
            // append a new block at the heap top
            mem_we       = 1'b1;
            mem_wa       = count_r[IDX_W-1:0];
            mem_wd.size  = need_r;
            mem_wd.free  = 1'b0;
            mem_wd.base  = heap_top_r;
            status_nxt   = STAT_OK;
            grown_nxt    = 1'b1;
            idx_nxt      = 6'(count_r);
            offs_nxt     = heap_top_r + OFFS_W'(HEADER_BYTES);
            heap_top_nxt = grow_end[OFFS_W-1:0];
            count_nxt    = count_r + CNT_W'(1);
          end
        end
      end

      ST_REL_CHK: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
        grown_nxt     = 1'b0;
        if (CMP_W'(rel_r) >= CMP_W'(count_r) || mem_q_r.free) begin
          status_nxt = STAT_BAD_REL;
          idx_nxt    = 6'd0;
          offs_nxt   = '0;
        end else begin
          mem_we      = 1'b1;
          mem_wa      = IDX_W'(rel_r);
          mem_wd      = mem_q_r;
          mem_wd.free = 1'b1;
          status_nxt  = STAT_OK;
          idx_nxt     = rel_r;
          offs_nxt    = mem_q_r.base + OFFS_W'(HEADER_BYTES);
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      heap_top_r  <= '0;
      rover_r     <= '0;
      rover_v_r   <= 1'b0;
      pend_v_r    <= 1'b0;
      found_r     <= 1'b0;
      phase1_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      heap_top_r  <= heap_top_nxt;
      rover_r     <= rover_nxt;
      rover_v_r   <= rover_v_nxt;
      pend_v_r    <= pend_v_nxt;
      found_r     <= found_nxt;
      phase1_r    <= phase1_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pol_r      <= pol_nxt;
    need_r     <= need_nxt;
    rel_r      <= rel_nxt;
    scan_i_r   <= scan_i_nxt;
    pend_idx_r <= pend_idx_nxt;
    pick_idx_r <= pick_idx_nxt;
    pick_ent_r <= pick_ent_nxt;
    best_exc_r <= best_exc_nxt;
    status_r   <= status_nxt;
    grown_r    <= grown_nxt;
    idx_r      <= idx_nxt;
    offs_r     <= offs_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_grown       = grown_r;
  assign out_block_index = idx_r;
  assign out_data_offset = offs_r;

  // ---------------- assertions ----------------
  // a result beat only follows a resolve, a release check or a zero size
  a_beat_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_RESOLVE || state_r == ST_REL_CHK ||
                        (state_r == ST_IDLE && start)))
    else $error("result beat without a finishing step");

  // a grown block bumps the block count by one and reports ok
  a_grow_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_grown) |->
      (count_r == $past(count_r) + CNT_W'(1) && status_r == STAT_OK))
    else $error("grown beat without a table append");

  // the block count never passes the table depth
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_BLOCKS))
    else $error("block count beyond table depth");

  // no read is outstanding once the sequencer is back at idle
  a_scan_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !pend_v_r)
    else $error("scan read left outstanding at idle");

endmodule
